### rtl/core/midc_pkg.sv
// Package for the midpoint circle raster block: widths, codes and the job record.
// Shared by midc_front, midc_queue, midc_back and midpoint_circle_raster.
`timescale 1ns / 1ps

package midc_pkg;

   localparam int COORD_BITS  = 16;
   localparam int RADIUS_BITS = 12;
   localparam int CIN_BITS    = 15;
   // x and y carry one sign bit above the radius; x may reach -1 on the final step
   localparam int POS_BITS    = RADIUS_BITS + 1;
   localparam int DEC_BITS    = RADIUS_BITS + 4;
   localparam int IDX_BITS    = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [CIN_BITS-1:0]   cin_type;
   typedef logic [RADIUS_BITS-1:0]       radius_type;
   typedef logic signed [POS_BITS-1:0]   pos_type;
   typedef logic signed [DEC_BITS-1:0]   dec_type;
   typedef logic [IDX_BITS-1:0]          idx_type;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;
   localparam logic KIND_POINT = 1'b0;
   localparam logic KIND_SPAN  = 1'b1;

   localparam idx_type LAST_POINT = idx_type'(7);
   localparam idx_type LAST_SPAN  = idx_type'(3);

   localparam pos_type POS_ONE = pos_type'(1);
   localparam dec_type DEC_ONE = dec_type'(1);

   // One iteration of the loop, as handed from the front to the back
   typedef struct packed {
      logic      fill;
      coord_type cx;
      coord_type cy;
      pos_type   x;
      pos_type   y;
      logic      done;
   } job_type;

endpackage

### rtl/core/midpoint_circle_raster.sv
// Top level of the midpoint circle raster block: front, job queue and back.
// Depends on midc_pkg, midc_front, midc_queue and midc_back.
//
//   channel  ports             moves on                      payload
//   request  req_push/req_full req_push & !req_full          mode, centre, radius, filled
//   result   rsp_pop/rsp_empty rsp_pop & !rsp_empty          kind, columns, row, last, done
//
// A start item only loads the circle state in the front; a productive step item pushes one job,
// which the back turns into eight results (outline) or four (filled), and the back pulls the
// next job from the queue as it issues the last result of the current one.
// Synchronous active-high reset clears the circle state, the queue and the result valid flag.
// A held result stalls the back; the two-entry queue lets two further steps be taken meanwhile.
`timescale 1ns / 1ps

module midpoint_circle_raster
   import midc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_mode,
   input  cin_type    req_center_x,
   input  cin_type    req_center_y,
   input  radius_type req_radius,
   input  logic       req_filled,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_kind,
   output coord_type  rsp_x_begin,
   output coord_type  rsp_x_finish,
   output coord_type  rsp_row,
   output logic       rsp_last,
   output logic       rsp_done_res
);

   logic    q_push;
   job_type q_in_data;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   job_type q_out_data;
   logic    req_accept;

   assign req_full   = q_full;
   assign req_accept = req_push && !q_full;

   midc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .mode     (req_mode),
      .center_x (req_center_x),
      .center_y (req_center_y),
      .radius   (req_radius),
      .filled   (req_filled),
      .q_push   (q_push),
      .q_data   (q_in_data)
   );

   midc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_out_data)
   );

   midc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_out_data),
      .q_pop        (q_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_kind     (rsp_kind),
      .rsp_x_begin  (rsp_x_begin),
      .rsp_x_finish (rsp_x_finish),
      .rsp_row      (rsp_row),
      .rsp_last     (rsp_last),
      .rsp_done_res (rsp_done_res)
   );

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_done_res) |-> rsp_last)
      else $error("done flag on a result that is not the last of its step");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_SPAN) |-> (rsp_x_begin <= rsp_x_finish))
      else $error("span with left column beyond right column");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into a full queue");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> rsp_empty)
      else $error("result presented straight after reset");

endmodule

### rtl/core/midc_front.sv
// Front part: takes items, holds the circle state, runs the decision update.
// Depends on midc_pkg; pushes one job per productive step into midc_queue.
`timescale 1ns / 1ps

module midc_front
   import midc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       mode,
   input  cin_type    center_x,
   input  cin_type    center_y,
   input  radius_type radius,
   input  logic       filled,
   output logic       q_push,
   output job_type    q_data
);

   logic      active_ff, active_in;
   logic      fill_ff, fill_in;
   coord_type cx_ff, cx_in;
   coord_type cy_ff, cy_in;
   pos_type   x_ff, x_in;
   pos_type   y_ff, y_in;
   dec_type   dec_ff, dec_in;

   pos_type   x_next;
   pos_type   y_next;
   dec_type   dec_next;
   logic      run;

   always_comb begin
      y_next = y_ff + POS_ONE;
      if (dec_ff <= dec_type'(0)) begin
         x_next   = x_ff;
         dec_next = dec_ff + (dec_type'(y_next) <<< 1) + DEC_ONE;
      end else begin
         x_next   = x_ff - POS_ONE;
         dec_next = dec_ff + ((dec_type'(y_next) - dec_type'(x_next)) <<< 1) + DEC_ONE;
      end
   end

   assign run = active_ff && (x_ff >= y_ff);

   always_comb begin
      active_in = active_ff;
      fill_in   = fill_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      dec_in    = dec_ff;
      q_push    = 1'b0;
      q_data.fill = fill_ff;
      q_data.cx   = cx_ff;
      q_data.cy   = cy_ff;
      q_data.x    = x_ff;
      q_data.y    = y_ff;
      q_data.done = x_next < y_next;
      if (accept) begin
         unique case (mode)
            MODE_START: begin
               active_in = 1'b1;
               fill_in   = filled;
               cx_in     = coord_type'(center_x);
               cy_in     = coord_type'(center_y);
               x_in      = pos_type'({1'b0, radius});
               y_in      = pos_type'(0);
               dec_in    = DEC_ONE - dec_type'({1'b0, radius});
            end
            MODE_STEP: begin
               // drop the step once the circle is complete
               if (run) begin
                  q_push = 1'b1;
                  x_in   = x_next;
                  y_in   = y_next;
                  dec_in = dec_next;
                  if (x_next < y_next) begin
                     active_in = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         fill_ff   <= 1'b0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         dec_ff    <= '0;
      end else begin
         active_ff <= active_in;
         fill_ff   <= fill_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         dec_ff    <= dec_in;
      end
   end

endmodule

### rtl/core/midc_queue.sv
// Two-entry job queue between the front and the back parts.
// Depends on midc_pkg for the job record.
`timescale 1ns / 1ps

module midc_queue
   import midc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output job_type pop_data
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = count_ff == 2'd2;
   assign valid    = count_ff != 2'd0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/midc_back.sv
// Back part: walks one job through its eight points or four spans into the result register.
// Depends on midc_pkg; pulls jobs from midc_queue.
`timescale 1ns / 1ps

module midc_back
   import midc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  job_type   q_data,
   output logic      q_pop,
   input  logic      rsp_pop,
   output logic      rsp_empty,
   output logic      rsp_kind,
   output coord_type rsp_x_begin,
   output coord_type rsp_x_finish,
   output coord_type rsp_row,
   output logic      rsp_last,
   output logic      rsp_done_res
);

   job_type   job_ff;
   logic      busy_ff, busy_in;
   idx_type   idx_ff, idx_in;
   logic      out_valid_ff, out_valid_in;
   logic      kind_ff, kind_in;
   coord_type xb_ff, xb_in;
   coord_type xf_ff, xf_in;
   coord_type row_ff, row_in;
   logic      last_ff, last_in;
   logic      done_ff, done_in;

   logic      out_free;
   logic      at_last;
   logic      swap;
   logic      neg_col;
   logic      neg_row;
   coord_type a_ext;
   coord_type b_ext;

   assign out_free = !out_valid_ff || rsp_pop;
   assign at_last  = idx_ff == (job_ff.fill ? LAST_SPAN : LAST_POINT);
   assign q_pop    = q_valid && (!busy_ff || (out_free && at_last));

   // octant of this index: swap x and y, mirror column, mirror row
   always_comb begin
      if (job_ff.fill) begin
         swap    = idx_ff[1];
         neg_col = 1'b0;
         neg_row = idx_ff[0];
      end else begin
         swap    = idx_ff[2];
         neg_col = idx_ff[0];
         neg_row = idx_ff[1];
      end
      a_ext = coord_type'(swap ? job_ff.y : job_ff.x);
      b_ext = coord_type'(swap ? job_ff.x : job_ff.y);
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      kind_in      = kind_ff;
      xb_in        = xb_ff;
      xf_in        = xf_ff;
      row_in       = row_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      if (busy_ff && out_free) begin
         out_valid_in = 1'b1;
         row_in       = neg_row ? job_ff.cy - b_ext : job_ff.cy + b_ext;
         last_in      = at_last;
         done_in      = at_last && job_ff.done;
         if (job_ff.fill) begin
            kind_in = KIND_SPAN;
            xb_in   = job_ff.cx - a_ext;
            xf_in   = job_ff.cx + a_ext;
         end else begin
            kind_in = KIND_POINT;
            xb_in   = neg_col ? job_ff.cx - a_ext : job_ff.cx + a_ext;
            xf_in   = xb_in;
         end
         idx_in = idx_ff + idx_type'(1);
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_data;
      end
      kind_ff <= kind_in;
      xb_ff   <= xb_in;
      xf_ff   <= xf_in;
      row_ff  <= row_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_x_begin  = xb_ff;
   assign rsp_x_finish = xf_ff;
   assign rsp_row      = row_ff;
   assign rsp_last     = last_ff;
   assign rsp_done_res = done_ff;

endmodule
